/* rtl/lmd_pkg.sv */
package lmd_pkg;

   localparam int MAX_COLS_DEFAULT    = 128;
   localparam int MAX_ROWS_DEFAULT    = 128;
   localparam int PIXEL_WIDTH_DEFAULT = 32;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam int POS_WIDTH       = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NUM_ROWS = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NUM_COLS = 1'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] SIZE_RESET = 8'd128;

   // controls one window cell: shift moves the chain, side picks the side input
   typedef struct packed {
      logic shift;
      logic side;
   } cell_ctl_type;

endpackage

/* rtl/lmd_line_store.sv */
module lmd_line_store #(
   parameter int ADDR_WIDTH = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr_a,
   input  logic [ADDR_WIDTH-1:0] rd_addr_b,
   output logic [DATA_WIDTH-1:0] rd_data_a,
   output logic [DATA_WIDTH-1:0] rd_data_b
);

   localparam int DEPTH = 1 << ADDR_WIDTH;

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_a_ff;
   logic [DATA_WIDTH-1:0] rd_b_ff;

   // read-first: a read at the write address returns the older row
   always_ff @(posedge clock) begin
      if (enable) begin
         mem_ff[wr_addr] <= wr_data;
         rd_a_ff         <= mem_ff[rd_addr_a];
         rd_b_ff         <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* rtl/lmd_cell.sv */
module lmd_cell #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                    clock,
   input  lmd_pkg::cell_ctl_type   ctl,
   input  logic [DATA_WIDTH-1:0]   nbr_data,
   input  logic [DATA_WIDTH-1:0]   side_data,
   output logic [DATA_WIDTH-1:0]   data
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.shift) begin
         data_in = ctl.side ? side_data : nbr_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* rtl/local_maximum_detector_unit.sv */
// pipeline: an accepted pixel is registered in stage one, and its result in the rsp output register
// throughput: one pixel per cycle while rsp is not stalled, set by one dual-read line store access per pixel
// and a two-cell window chain that shifts once per pixel
// reset: counters back to row 1 column 1, found flag and valids clear, sizes go to 128;
// the line store is not cleared and needs no clearing pass
module local_maximum_detector_unit #(
   parameter int MAX_COLS    = lmd_pkg::MAX_COLS_DEFAULT,
   parameter int MAX_ROWS    = lmd_pkg::MAX_ROWS_DEFAULT,
   parameter int PIXEL_WIDTH = lmd_pkg::PIXEL_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [PIXEL_WIDTH-1:0]        req_pixel_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_is_none,
   output logic signed [PIXEL_WIDTH-1:0]        rsp_peak_value,
   output logic [lmd_pkg::POS_WIDTH-1:0]        rsp_peak_row,
   output logic [lmd_pkg::POS_WIDTH-1:0]        rsp_peak_col,
   input  logic                                 csr_write_en,
   input  logic [lmd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [lmd_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);

   localparam int CCW    = $clog2(MAX_COLS + 1);
   localparam int RCW    = $clog2(MAX_ROWS + 1);
   localparam int AW     = $clog2(MAX_COLS);
   localparam int SWR    = (RCW > lmd_pkg::CSR_DATA_WIDTH) ? RCW : lmd_pkg::CSR_DATA_WIDTH;
   localparam int SWC    = (CCW > lmd_pkg::CSR_DATA_WIDTH) ? CCW : lmd_pkg::CSR_DATA_WIDTH;
   localparam int NCELLS = 2;
   localparam int PW     = lmd_pkg::POS_WIDTH;

   // configuration
   logic [lmd_pkg::CSR_DATA_WIDTH-1:0] num_rows_ff;
   logic [lmd_pkg::CSR_DATA_WIDTH-1:0] num_cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= lmd_pkg::SIZE_RESET;
         num_cols_ff <= lmd_pkg::SIZE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            lmd_pkg::REG_NUM_ROWS: num_rows_ff <= csr_write_data;
            lmd_pkg::REG_NUM_COLS: num_cols_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // effective sizes: zero acts as one, large values saturate
   logic [SWR-1:0] rows_ext;
   logic [SWC-1:0] cols_ext;
   logic [RCW-1:0] eff_rows;
   logic [CCW-1:0] eff_cols;

   always_comb begin
      rows_ext = SWR'(num_rows_ff);
      cols_ext = SWC'(num_cols_ff);
      if (rows_ext == '0) begin
         eff_rows = RCW'(1);
      end else if (rows_ext > SWR'(MAX_ROWS)) begin
         eff_rows = RCW'(MAX_ROWS);
      end else begin
         eff_rows = rows_ext[RCW-1:0];
      end
      if (cols_ext == '0) begin
         eff_cols = CCW'(1);
      end else if (cols_ext > SWC'(MAX_COLS)) begin
         eff_cols = CCW'(MAX_COLS);
      end else begin
         eff_cols = cols_ext[CCW-1:0];
      end
   end

   // handshake
   logic s1_valid_ff;
   logic s1_valid_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;
   logic advance;
   logic accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // position counters
   logic [RCW-1:0] row_cnt_ff;
   logic [RCW-1:0] row_cnt_in;
   logic [CCW-1:0] col_cnt_ff;
   logic [CCW-1:0] col_cnt_in;
   logic           is_cand;
   logic           row_end;
   logic           frame_end;
   logic           first_col;
   logic [AW-1:0]  idx_here;
   logic [AW-1:0]  idx_right;

   always_comb begin
      is_cand   = (row_cnt_ff >= RCW'(3)) && (row_cnt_ff <= eff_rows)
                  && (col_cnt_ff >= CCW'(2))
                  && (({1'b0, col_cnt_ff} + (CCW+1)'(1)) <= {1'b0, eff_cols});
      row_end   = col_cnt_ff >= eff_cols;
      frame_end = row_end && (row_cnt_ff >= eff_rows);
      first_col = col_cnt_ff == CCW'(1);
      idx_here  = AW'(col_cnt_ff - CCW'(1));
      idx_right = col_cnt_ff[AW-1:0];
      row_cnt_in = row_cnt_ff;
      col_cnt_in = col_cnt_ff;
      if (accept) begin
         if (row_end) begin
            col_cnt_in = CCW'(1);
            row_cnt_in = frame_end ? RCW'(1) : row_cnt_ff + RCW'(1);
         end else begin
            col_cnt_in = col_cnt_ff + CCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff <= RCW'(1);
         col_cnt_ff <= CCW'(1);
      end else begin
         row_cnt_ff <= row_cnt_in;
         col_cnt_ff <= col_cnt_in;
      end
   end

   // line store: two row banks, bank picked by row parity
   logic [AW:0]            wr_addr;
   logic [AW:0]            rd_addr_a;
   logic [AW:0]            rd_addr_b;
   logic [PIXEL_WIDTH-1:0] rd_data_a;
   logic [PIXEL_WIDTH-1:0] rd_data_b;

   // at column one the upper port fetches column one of the previous row for the window
   assign wr_addr   = {row_cnt_ff[0], idx_here};
   assign rd_addr_a = first_col ? {~row_cnt_ff[0], idx_here} : {row_cnt_ff[0], idx_here};
   assign rd_addr_b = {~row_cnt_ff[0], idx_right};

   lmd_line_store #(
      .ADDR_WIDTH (AW + 1),
      .DATA_WIDTH (PIXEL_WIDTH)
   ) u_line_store (
      .clock     (clock),
      .enable    (accept),
      .wr_addr   (wr_addr),
      .wr_data   (req_pixel_value),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // stage one item
   logic signed [PIXEL_WIDTH-1:0] s1_pix_ff;
   logic                          s1_cand_ff;
   logic                          s1_last_ff;
   logic                          s1_first_ff;
   logic [PW-1:0]                 s1_row_ff;
   logic [PW-1:0]                 s1_col_ff;
   logic [PW-1:0]                 s1_rows_ff;
   logic [PW-1:0]                 s1_cols_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff   <= req_pixel_value;
         s1_cand_ff  <= is_cand;
         s1_last_ff  <= frame_end;
         s1_first_ff <= first_col;
         s1_row_ff   <= PW'(row_cnt_ff - RCW'(1));
         s1_col_ff   <= PW'(col_cnt_ff);
         s1_rows_ff  <= PW'(eff_rows);
         s1_cols_ff  <= PW'(eff_cols);
      end
   end

   // window chain: cell 0 holds the centre, cell 1 the left neighbor
   logic [PIXEL_WIDTH-1:0] cell_data [NCELLS];
   logic [PIXEL_WIDTH-1:0] cell_side [NCELLS];
   logic [PIXEL_WIDTH-1:0] cell_nbr  [NCELLS];
   lmd_pkg::cell_ctl_type  cell_ctl;

   assign cell_ctl.shift = advance;
   assign cell_ctl.side  = s1_first_ff;
   assign cell_side[0]   = rd_data_b;
   assign cell_side[1]   = rd_data_a;
   assign cell_nbr[0]    = rd_data_b;

   genvar gi;
   generate
      for (gi = 1; gi < NCELLS; gi++) begin : g_nbr
         assign cell_nbr[gi] = cell_data[gi-1];
      end
      for (gi = 0; gi < NCELLS; gi++) begin : g_cell
         lmd_cell #(
            .DATA_WIDTH (PIXEL_WIDTH)
         ) u_cell (
            .clock     (clock),
            .ctl       (cell_ctl),
            .nbr_data  (cell_nbr[gi]),
            .side_data (cell_side[gi]),
            .data      (cell_data[gi])
         );
      end
   endgenerate

   // decision
   logic signed [PIXEL_WIDTH-1:0] ctr;
   logic signed [PIXEL_WIDTH-1:0] lft;
   logic signed [PIXEL_WIDTH-1:0] rgt;
   logic signed [PIXEL_WIDTH-1:0] up;
   logic                          hit;
   logic                          none;
   logic                          found_ff;
   logic                          found_in;

   always_comb begin
      ctr  = $signed(cell_data[0]);
      lft  = $signed(cell_data[1]);
      rgt  = $signed(rd_data_b);
      up   = $signed(rd_data_a);
      hit  = s1_cand_ff && (ctr > up) && (ctr > s1_pix_ff) && (ctr > lft) && (ctr > rgt);
      none = s1_last_ff && !found_ff && !hit;
      found_in = found_ff;
      if (advance) begin
         found_in = s1_last_ff ? 1'b0 : (found_ff || hit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   // output register
   logic                          rsp_is_none_ff;
   logic signed [PIXEL_WIDTH-1:0] rsp_value_ff;
   logic [PW-1:0]                 rsp_row_ff;
   logic [PW-1:0]                 rsp_col_ff;
   logic                          load_rsp;

   assign load_rsp = advance && (hit || none);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_is_none_ff <= none;
         rsp_value_ff   <= hit ? ctr : '0;
         rsp_row_ff     <= none ? s1_rows_ff : s1_row_ff;
         rsp_col_ff     <= none ? s1_cols_ff : s1_col_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_none    = rsp_is_none_ff;
   assign rsp_peak_value = rsp_value_ff;
   assign rsp_peak_row   = rsp_row_ff;
   assign rsp_peak_col   = rsp_col_ff;

   // checks
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with no item in stage one");

   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result appeared without an item in stage one");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (col_cnt_ff >= CCW'(1)) && (col_cnt_ff <= CCW'(MAX_COLS)))
      else $error("column counter out of range");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && frame_end) |=> (row_cnt_ff == RCW'(1) && col_cnt_ff == CCW'(1)))
      else $error("counters did not wrap at frame end");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      advance |-> !(hit && none))
      else $error("hit and none for the same item");

endmodule
